### sv/ccmf_pkg.sv
// ---------------------------------------------------------------------------
// ccmf_pkg : shared types and constants for the column contour features
// Register map, column summary word and configuration bundle.
// ---------------------------------------------------------------------------
package ccmf_pkg;

	localparam int MaxRows = 256;
	localparam int RowW    = $clog2(MaxRows);     // row index width
	localparam int CntW    = RowW + 1;            // holds MaxRows itself
	localparam int S0W     = 16;
	localparam int S1W     = 24;
	localparam int S2W     = 32;

	// register indexes (byte address 4*i)
	localparam logic [1:0] REG_CONTOUR = 2'd0;
	localparam logic [1:0] REG_STROKE  = 2'd1;
	localparam logic [1:0] REG_CENTER  = 2'd2;
	localparam logic [1:0] REG_ROWS    = 2'd3;

	typedef struct packed {
		logic [7:0] contour_thr;
		logic [7:0] stroke_thr;
		logic [7:0] center_row;
		logic [8:0] rows_in_use;
	} cfg_t;

	// one finished column handed from front to back
	typedef struct packed {
		logic [RowW-1:0] top;
		logic [RowW-1:0] bot;
		logic [S0W-1:0]  s0;
		logic [S1W-1:0]  s1;
		logic [S2W-1:0]  s2;
		logic [7:0]      strokes;
		logic [RowW-1:0] tc;
	} col_t;

endpackage

### sv/ccmf_front.sv
// ---------------------------------------------------------------------------
// ccmf_front : per-pixel contour tracking and moment accumulation
// Emits one column summary word at the last row of each column.
// ---------------------------------------------------------------------------
module ccmf_front import ccmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        take,
	input  logic [7:0]  pixel,
	output logic        push,
	output col_t        item
);

	logic [RowW-1:0] row_q;
	logic [15:0]     rsq_q;
	logic            ink_seen_q;
	logic [RowW-1:0] top_q, last_q;
	logic [S0W-1:0]  c0_q, p0_q;
	logic [S1W-1:0]  c1_q, p1_q;
	logic [S2W-1:0]  c2_q, p2_q;
	logic            black_q;
	logic [7:0]      run0_q, run1_q;
	logic [7:0]      cp_q;
	logic [15:0]     cs1_q;
	logic [23:0]     cs2_q;

	logic [CntW-1:0] rows;
	logic [RowW-1:0] tc;
	logic            last, ink, blk, first;
	logic [15:0]     prod1;
	logic [23:0]     prod2;
	logic            ink_seen_n, black_n;
	logic [RowW-1:0] top_n, last_n;
	logic [S0W-1:0]  c0_n, p0_n;
	logic [S1W-1:0]  c1_n, p1_n;
	logic [S2W-1:0]  c2_n, p2_n;
	logic [7:0]      run0_n, run1_n, cp_n;
	logic [15:0]     cs1_n;
	logic [23:0]     cs2_n;

	always_comb begin
		if (cfg.rows_in_use == '0)
			rows = CntW'(1);
		else if (cfg.rows_in_use > 9'(MaxRows))
			rows = CntW'(MaxRows);
		else
			rows = CntW'(cfg.rows_in_use);
		if (CntW'(cfg.center_row) > rows - CntW'(1))
			tc = RowW'(rows - CntW'(1));
		else
			tc = RowW'(cfg.center_row);
	end

	assign last  = ({1'b0, row_q} + CntW'(1)) >= rows;
	assign ink   = pixel >= cfg.contour_thr;
	assign blk   = pixel > cfg.stroke_thr;
	assign first = ink && !ink_seen_q;
	assign prod1 = 16'(row_q) * 16'(pixel);
	assign prod2 = 24'(rsq_q) * 24'(pixel);

	always_comb begin
		ink_seen_n = ink_seen_q | ink;
		top_n  = first ? row_q : top_q;
		last_n = last_q;
		c0_n = c0_q; c1_n = c1_q; c2_n = c2_q;
		p0_n = p0_q; p1_n = p1_q; p2_n = p2_q;
		run0_n = run0_q; run1_n = run1_q;
		black_n = black_q;
		cp_n  = cp_q; cs1_n = cs1_q; cs2_n = cs2_q;
		if (row_q == tc) begin
			cp_n  = pixel;
			cs1_n = prod1;
			cs2_n = prod2;
		end
		if (ink_seen_n) begin
			p0_n = p0_q + S0W'(pixel);
			p1_n = p1_q + S1W'(prod1);
			p2_n = p2_q + S2W'(prod2);
			if (blk && !(black_q && !first))
				run1_n = run1_q + 8'd1;
			black_n = blk;
			if (ink) begin
				c0_n = c0_q + p0_n;
				c1_n = c1_q + p1_n;
				c2_n = c2_q + p2_n;
				p0_n = '0; p1_n = '0; p2_n = '0;
				run0_n = run0_q + run1_n;
				run1_n = '0;
				last_n = row_q;
			end
		end
	end

	always_comb begin
		item.tc = tc;
		if (ink_seen_n) begin
			item.top = top_n;
			item.bot = last_n;
			item.s0 = c0_n;
			item.s1 = c1_n;
			item.s2 = c2_n;
			item.strokes = run0_n;
		end else begin
			item.top = tc;
			item.bot = tc;
			item.s0 = S0W'(cp_n);
			item.s1 = S1W'(cs1_n);
			item.s2 = S2W'(cs2_n);
			item.strokes = (cp_n > cfg.stroke_thr) ? 8'd1 : 8'd0;
		end
	end

	assign push = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0; rsq_q <= '0; ink_seen_q <= 1'b0;
			top_q <= '0; last_q <= '0;
			c0_q <= '0; c1_q <= '0; c2_q <= '0;
			p0_q <= '0; p1_q <= '0; p2_q <= '0;
			black_q <= 1'b0; run0_q <= '0; run1_q <= '0;
			cp_q <= '0; cs1_q <= '0; cs2_q <= '0;
		end else if (take) begin
			if (last) begin
				row_q <= '0; rsq_q <= '0; ink_seen_q <= 1'b0;
				top_q <= '0; last_q <= '0;
				c0_q <= '0; c1_q <= '0; c2_q <= '0;
				p0_q <= '0; p1_q <= '0; p2_q <= '0;
				black_q <= 1'b0; run0_q <= '0; run1_q <= '0;
				cp_q <= '0; cs1_q <= '0; cs2_q <= '0;
			end else begin
				row_q <= row_q + RowW'(1);
				rsq_q <= rsq_q + {7'd0, row_q, 1'b1};
				ink_seen_q <= ink_seen_n;
				top_q <= top_n; last_q <= last_n;
				c0_q <= c0_n; c1_q <= c1_n; c2_q <= c2_n;
				p0_q <= p0_n; p1_q <= p1_n; p2_q <= p2_n;
				black_q <= black_n; run0_q <= run0_n; run1_q <= run1_n;
				cp_q <= cp_n; cs1_q <= cs1_n; cs2_q <= cs2_n;
			end
		end
	end

endmodule

### sv/ccmf_queue.sv
// ---------------------------------------------------------------------------
// ccmf_queue : two-entry queue of column summary words
// Decouples the pixel front from the arithmetic back.
// ---------------------------------------------------------------------------
module ccmf_queue import ccmf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  col_t wr_data,
	input  logic pop,
	output col_t rd_data,
	output logic full,
	output logic empty
);

	col_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

### sv/ccmf_back.sv
// ---------------------------------------------------------------------------
// ccmf_back : column-end arithmetic
// Products, three restoring divisions and an integer root, one step a cycle.
// ---------------------------------------------------------------------------
module ccmf_back import ccmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  col_t        head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  top_contour,
	output logic [7:0]  bottom_contour,
	output logic [7:0]  span,
	output logic [15:0] ink_sum,
	output logic [15:0] mean_row_x256,
	output logic [15:0] spread_x256,
	output logic [15:0] density,
	output logic [7:0]  strokes
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MA    = 4'd1;
	localparam logic [3:0] ST_MB    = 4'd2;
	localparam logic [3:0] ST_MD    = 4'd3;
	localparam logic [3:0] ST_CMP   = 4'd4;
	localparam logic [3:0] ST_DLOAD = 4'd5;
	localparam logic [3:0] ST_DRUN  = 4'd6;
	localparam logic [3:0] ST_DSTOR = 4'd7;
	localparam logic [3:0] ST_SQRT  = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	localparam logic [1:0] DIV_MEAN  = 2'd0;
	localparam logic [1:0] DIV_DENS  = 2'd1;
	localparam logic [1:0] DIV_SCALE = 2'd2;

	logic [3:0]  st_q;
	logic [1:0]  sel_q;
	logic [5:0]  cnt_q;
	col_t        it_q;
	logic [7:0]  span_q;
	logic [47:0] a_q, b_q, num_q;
	logic [31:0] d_q;
	logic        big_q;
	logic [63:0] dvd_q;
	logic [31:0] dvs_q, rem_q;
	logic [15:0] mean_q, dens_q;
	logic [31:0] v_q, res_q, bit_q;
	logic        out_valid_q;

	logic [32:0] shifted;
	logic        ge;
	logic [53:0] num100;
	logic [31:0] rb;

	assign shifted = {rem_q, dvd_q[63]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign num100  = {num_q, 6'd0} + {1'b0, num_q, 5'd0} + {4'd0, num_q, 2'd0};
	assign rb      = res_q + bit_q;
	assign pop     = (st_q == ST_IDLE) && !empty;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				it_q   <= head;
				span_q <= head.bot - head.top;
			end
			ST_MA: a_q <= 48'(it_q.s0) * 48'(it_q.s2);
			ST_MB: b_q <= 48'(it_q.s1) * 48'(it_q.s1);
			ST_MD: begin
				d_q   <= 32'(it_q.s0) * 32'(it_q.s0);
				num_q <= (a_q > b_q) ? a_q - b_q : '0;
			end
			ST_CMP: big_q <= (it_q.s0 != '0) && (num100 >= 54'(d_q));
			ST_DLOAD: begin
				rem_q <= '0;
				case (sel_q)
					DIV_MEAN: begin
						dvd_q <= {32'd0, it_q.s1, 8'd0};
						dvs_q <= 32'(it_q.s0);
					end
					DIV_DENS: begin
						dvd_q <= 64'(it_q.s0);
						dvs_q <= 32'(span_q);
					end
					default: begin
						dvd_q <= {num_q, 16'd0};
						dvs_q <= d_q;
					end
				endcase
			end
			ST_DRUN: begin
				rem_q <= ge ? 32'(shifted - {1'b0, dvs_q}) : shifted[31:0];
				dvd_q <= {dvd_q[62:0], ge};
			end
			ST_DSTOR: begin
				case (sel_q)
					DIV_MEAN:
						mean_q <= (it_q.s0 == '0) ? {it_q.tc, 8'd0} : dvd_q[15:0];
					DIV_DENS:
						dens_q <= (span_q == '0) ? '0 : dvd_q[15:0];
					default: begin
						v_q   <= dvd_q[31:0];
						res_q <= '0;
						bit_q <= 32'h4000_0000;
					end
				endcase
			end
			ST_SQRT: begin
				if (v_q >= rb) begin
					v_q   <= v_q - rb;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: ;
		endcase
		if (st_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			top_contour    <= it_q.top;
			bottom_contour <= it_q.bot;
			span           <= span_q;
			ink_sum        <= it_q.s0;
			mean_row_x256  <= mean_q;
			spread_x256    <= big_q ? res_q[15:0] : '0;
			density        <= dens_q;
			strokes        <= it_q.strokes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; sel_q <= DIV_MEAN; cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE:  if (!empty) st_q <= ST_MA;
				ST_MA:    st_q <= ST_MB;
				ST_MB:    st_q <= ST_MD;
				ST_MD:    st_q <= ST_CMP;
				ST_CMP: begin
					sel_q <= DIV_MEAN;
					st_q  <= ST_DLOAD;
				end
				ST_DLOAD: begin
					cnt_q <= '0;
					st_q  <= ST_DRUN;
				end
				ST_DRUN: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) st_q <= ST_DSTOR;
				end
				ST_DSTOR: begin
					cnt_q <= '0;
					if (sel_q == DIV_SCALE) begin
						st_q <= ST_SQRT;
					end else begin
						sel_q <= sel_q + 2'd1;
						st_q  <= ST_DLOAD;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd15) st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/column_contour_moment_features.sv
// ---------------------------------------------------------------------------
// column_contour_moment_features : contour and moment features of a column
// Per-pixel front, two-word queue, sequential arithmetic back end.
// ---------------------------------------------------------------------------
// Usage
//  - Input channel: one pixel word per accepted cycle (in_valid high,
//    in_stall low), top row first; rows_in_use words make one column.
//  - Output channel: one result word per column (out_valid / out_stall),
//    held steady while out_stall is high.
//  - Front takes one pixel a cycle; it stalls only when both queue slots
//    hold finished columns not yet picked up by the back end.
//  - Back end: pick-up, the products s0*s2, s1*s1 and s0*s0, a compare,
//    three 64-step restoring divisions on one shared divider, a 16-step
//    integer root and hand-off, one column at a time.
//  - Sustained rate: one pixel a cycle while the back end finishes each
//    column before the queue fills; otherwise the back end limits it.
//  - A stalled receiver holds the result register; the back end waits with
//    its next word finished, and the front keeps filling the queue.
//  - Reset clears the column state, queue and handshake; registers return
//    to 51 / 204 / 128 / 256. Configuration only while idle.
// ---------------------------------------------------------------------------
module column_contour_moment_features import ccmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  top_contour,
	output logic [7:0]  bottom_contour,
	output logic [7:0]  span,
	output logic [15:0] ink_sum,
	output logic [15:0] mean_row_x256,
	output logic [15:0] spread_x256,
	output logic [15:0] density,
	output logic [7:0]  strokes
);

	cfg_t cfg_q;
	logic take, push, pop, full, empty;
	col_t item, head;

	// register file: writes land in the access phase
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.contour_thr <= 8'd51;
			cfg_q.stroke_thr  <= 8'd204;
			cfg_q.center_row  <= 8'd128;
			cfg_q.rows_in_use <= 9'd256;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_CONTOUR: cfg_q.contour_thr <= pwdata[7:0];
				REG_STROKE:  cfg_q.stroke_thr  <= pwdata[7:0];
				REG_CENTER:  cfg_q.center_row  <= pwdata[7:0];
				REG_ROWS:    cfg_q.rows_in_use <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CONTOUR: prdata = {24'd0, cfg_q.contour_thr};
			REG_STROKE:  prdata = {24'd0, cfg_q.stroke_thr};
			REG_CENTER:  prdata = {24'd0, cfg_q.center_row};
			REG_ROWS:    prdata = {23'd0, cfg_q.rows_in_use};
			default:     prdata = '0;
		endcase
	end

	// full queue holds off the pixel source
	assign in_stall = full;
	assign take     = in_valid && !full;

	ccmf_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .take(take), .pixel(pixel),
		.push(push), .item(item)
	);

	ccmf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_data(item), .pop(pop),
		.rd_data(head), .full(full), .empty(empty)
	);

	ccmf_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(head), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.top_contour(top_contour), .bottom_contour(bottom_contour),
		.span(span), .ink_sum(ink_sum), .mean_row_x256(mean_row_x256),
		.spread_x256(spread_x256), .density(density), .strokes(strokes)
	);

endmodule
